@@ rtl/core/biou_pkg.sv @@
// Shared types and constants for the box intersection-over-union unit.
`default_nettype none
package biou_pkg;

  localparam int COORD_W         = 16;
  localparam int COORD_FRAC_BITS = 15;
  localparam int SIZE_W          = 12;
  localparam int PROD_W          = COORD_W + SIZE_W;
  localparam int PIX_W           = PROD_W - COORD_FRAC_BITS;
  localparam int EXT_W           = PIX_W + 1;
  localparam int AREA_W          = 2 * EXT_W;
  localparam int SUM_W           = AREA_W + 1;
  localparam int REM_W           = SUM_W + 1;
  localparam int RATIO_FRAC      = 16;
  localparam int RATIO_W         = RATIO_FRAC + 1;
  localparam int DIV_STEPS       = RATIO_FRAC;
  localparam int CFG_IDX_W       = 1;

  // Register stages: scale, corners, areas, sum, union, divide steps, output.
  localparam int PIPE_LAT        = 5 + DIV_STEPS + 1;

  localparam logic [RATIO_W-1:0]   RATIO_ONE    = RATIO_W'(1) << RATIO_FRAC;
  localparam logic [SIZE_W-1:0]    HEIGHT_RESET = SIZE_W'(360);
  localparam logic [SIZE_W-1:0]    WIDTH_RESET  = SIZE_W'(640);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [COORD_W-1:0] truth_top;
    logic [COORD_W-1:0] truth_left;
    logic [COORD_W-1:0] truth_bottom;
    logic [COORD_W-1:0] truth_right;
    logic [COORD_W-1:0] guess_top;
    logic [COORD_W-1:0] guess_left;
    logic [COORD_W-1:0] guess_bottom;
    logic [COORD_W-1:0] guess_right;
  } box_pair_t;

  typedef struct packed {
    logic [RATIO_W-1:0] overlap_ratio;
    logic               disjoint;
  } iou_result_t;

endpackage
`default_nettype wire

@@ rtl/core/box_iou_unit.sv @@
// Top level of the box intersection-over-union unit: a fully pipelined datapath.
`default_nettype none
//
// Usage
//   Input channel: drive a ground-truth box and a predicted box on boxes and
//   pulse start. The word is taken at a rising edge where start is high and
//   busy is low. busy is high while rst is held and in the cycle after it is released;
//   otherwise a new word may be offered in every cycle.
//   Result channel: done is high for exactly one cycle with the ratio and the
//   disjoint flag on result. The receiver cannot hold results off and none is
//   needed: there is no back-pressure anywhere in the pipe.
//   Configuration: cfg_we with cfg_index 0 writes image_height, index 1 writes
//   image_width. Write only while no word is in flight.
// Pipeline and throughput
//   A word passes through one stage of coordinate scaling multipliers, one
//   of corner min/max and extents, one of area multipliers, one for the area
//   sum, one for union and saturation check, sixteen restoring-divider stages
//   (one quotient bit per stage), and the output register. One word per
//   cycle sustained while busy is low.
// Reset
//   rst clears all valid bits and reloads image_height = 360, image_width = 640.
//
module box_iou_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire biou_pkg::box_pair_t                 boxes,
  output      logic                                done,
  output      biou_pkg::iou_result_t               result,
  input  wire logic                                cfg_we,
  input  wire logic [biou_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [biou_pkg::SIZE_W-1:0]         cfg_data
);
  import biou_pkg::*;

  // Scale a normalized coordinate to a truncated integer pixel.
  function automatic logic [PIX_W-1:0] to_pixel(input logic [COORD_W-1:0] coord,
                                                input logic [SIZE_W-1:0] size);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(coord) * PROD_W'(size);
    return prod[PROD_W-1:COORD_FRAC_BITS];
  endfunction

  // |a-b|+1, one bit wider than the coordinates.
  function automatic logic [EXT_W-1:0] extent(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return EXT_W'(diff) + EXT_W'(1);
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0] image_height;
  logic [SIZE_W-1:0] image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= HEIGHT_RESET;
      image_width  <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off words while rst is held and in the cycle after it is released.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic accept;
  assign accept = start && !busy;

  // Stage 1: scale all eight coordinates to pixels.
  logic             s1_vld;
  logic [PIX_W-1:0] s1_t_top, s1_t_left, s1_t_bot, s1_t_right;
  logic [PIX_W-1:0] s1_g_top, s1_g_left, s1_g_bot, s1_g_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_t_top   <= to_pixel(boxes.truth_top,    image_height);
    s1_t_left  <= to_pixel(boxes.truth_left,   image_width);
    s1_t_bot   <= to_pixel(boxes.truth_bottom, image_height);
    s1_t_right <= to_pixel(boxes.truth_right,  image_width);
    s1_g_top   <= to_pixel(boxes.guess_top,    image_height);
    s1_g_left  <= to_pixel(boxes.guess_left,   image_width);
    s1_g_bot   <= to_pixel(boxes.guess_bottom, image_height);
    s1_g_right <= to_pixel(boxes.guess_right,  image_width);
  end

  // Stage 2: intersection corners, overlap test and box extents.
  logic             s2_vld;
  logic             s2_disj;
  logic [EXT_W-1:0] s2_ih, s2_iw, s2_th, s2_tw, s2_gh, s2_gw;
  logic [PIX_W-1:0] r1, c1, r2, c2;

  always_comb begin
    r1 = (s1_t_top  > s1_g_top)   ? s1_t_top   : s1_g_top;
    c1 = (s1_t_left > s1_g_left)  ? s1_t_left  : s1_g_left;
    r2 = (s1_t_bot  < s1_g_bot)   ? s1_t_bot   : s1_g_bot;
    c2 = (s1_t_right < s1_g_right) ? s1_t_right : s1_g_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_disj <= (r1 > r2) || (c1 > c2);
    s2_ih   <= EXT_W'(r2 - r1) + EXT_W'(1);
    s2_iw   <= EXT_W'(c2 - c1) + EXT_W'(1);
    s2_th   <= extent(s1_t_bot,   s1_t_top);
    s2_tw   <= extent(s1_t_right, s1_t_left);
    s2_gh   <= extent(s1_g_bot,   s1_g_top);
    s2_gw   <= extent(s1_g_right, s1_g_left);
  end

  // Stage 3: intersection and box areas.
  logic              s3_vld;
  logic              s3_disj;
  logic [AREA_W-1:0] s3_inter, s3_area_t, s3_area_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_disj   <= s2_disj;
    s3_inter  <= AREA_W'(s2_ih) * AREA_W'(s2_iw);
    s3_area_t <= AREA_W'(s2_th) * AREA_W'(s2_tw);
    s3_area_g <= AREA_W'(s2_gh) * AREA_W'(s2_gw);
  end

  // Stage 4: sum of both areas.
  logic              s4_vld;
  logic              s4_disj;
  logic [AREA_W-1:0] s4_inter;
  logic [SUM_W-1:0]  s4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_disj  <= s3_disj;
    s4_inter <= s3_inter;
    s4_sum   <= SUM_W'(s3_area_t) + SUM_W'(s3_area_g);
  end

  // Stage 5 feeds the divider: union, and saturation when union <= inter,
  // which is the same as sum <= 2*inter.
  logic [REM_W-1:0]      dv_rem  [DIV_STEPS+1];
  logic [SUM_W-1:0]      dv_div  [DIV_STEPS+1];
  logic [RATIO_FRAC-1:0] dv_quot [DIV_STEPS+1];
  logic                  dv_sat  [DIV_STEPS+1];
  logic                  dv_disj [DIV_STEPS+1];
  logic                  dv_vld  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    dv_rem[0]  <= REM_W'(s4_inter);
    dv_div[0]  <= s4_sum - SUM_W'(s4_inter);
    dv_quot[0] <= '0;
    dv_sat[0]  <= (REM_W'(s4_sum) <= (REM_W'(s4_inter) << 1));
    dv_disj[0] <= s4_disj;
  end

  // Restoring divider, one quotient bit per stage. The remainder starts
  // below the divisor whenever the ratio is below one.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [REM_W-1:0] shifted;
    logic             fits;

    always_comb begin
      shifted = {dv_rem[k][REM_W-2:0], 1'b0};
      fits    = shifted >= REM_W'(dv_div[k]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem[k+1]  <= fits ? (shifted - REM_W'(dv_div[k])) : shifted;
      dv_div[k+1]  <= dv_div[k];
      dv_quot[k+1] <= {dv_quot[k][RATIO_FRAC-2:0], fits};
      dv_sat[k+1]  <= dv_sat[k];
      dv_disj[k+1] <= dv_disj[k];
    end
  end

  // Output register: pick zero, one or the quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    result.disjoint <= dv_disj[DIV_STEPS];
    if (dv_disj[DIV_STEPS]) begin
      result.overlap_ratio <= '0;
    end else if (dv_sat[DIV_STEPS]) begin
      result.overlap_ratio <= RATIO_ONE;
    end else begin
      result.overlap_ratio <= RATIO_W'(dv_quot[DIV_STEPS]);
    end
  end

  // Every accepted word comes out as a done strobe at the end of the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("result strobe missing at fixed latency");

  // A disjoint pair must report a zero ratio.
  a_disjoint_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.disjoint |-> result.overlap_ratio == '0)
    else $error("disjoint result with nonzero ratio");

  // The ratio never exceeds one.
  a_ratio_max: assert property (@(posedge clk) disable iff (rst)
    done |-> result.overlap_ratio <= RATIO_ONE)
    else $error("ratio above one");

endmodule
`default_nettype wire
